### src/mouse_cursor_register_file_top_defines.svh
// Assertion macros for the mouse cursor register file.
`ifndef MOUSE_CURSOR_REGISTER_FILE_TOP_DEFINES_SVH
`define MOUSE_CURSOR_REGISTER_FILE_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define MCRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define MCRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mcrf_pkg.sv
`default_nettype none

package mcrf_pkg;

  localparam int unsigned CURSOR_SIDE_DEF = 16;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_BUTTON  = 2'd2,
    KIND_REFRESH = 2'd3
  } kind_e;

  localparam logic [3:0] OFS_X_HI  = 4'd0;
  localparam logic [3:0] OFS_X_LO  = 4'd1;
  localparam logic [3:0] OFS_Y_HI  = 4'd2;
  localparam logic [3:0] OFS_Y_LO  = 4'd3;
  localparam logic [3:0] OFS_XOFS  = 4'd4;
  localparam logic [3:0] OFS_YOFS  = 4'd5;
  localparam logic [3:0] OFS_WHEEL = 4'd6;
  localparam logic [3:0] OFS_FLAGS = 4'd7;
  localparam logic [3:0] OFS_INDEX = 4'd8;
  localparam logic [3:0] OFS_DATA  = 4'd9;

  localparam logic [7:0] UNMAPPED_VALUE = 8'hCC;

  typedef struct packed {
    logic [3:0] offset;
    logic [7:0] data;
    logic [7:0] button_number;
    logic       button_pressed;
    logic [7:0] click_count;
  } req_t;

endpackage

`default_nettype wire

### src/mouse_cursor_register_file_top.sv
// An accepted request is held in the s1 registers, then its result in out_data_q.
// Throughput: one request per cycle unless the output stalls; the bitmap RAM read
// launches on acceptance. Reset (rst_ni low, asynchronous) clears the state
// registers and the bitmap valid flags, so the whole bitmap reads as zero at once.
`default_nettype none
`include "mouse_cursor_register_file_top_defines.svh"

module mouse_cursor_register_file_top
  import mcrf_pkg::*;
#(
  parameter int unsigned CURSOR_SIDE = CURSOR_SIDE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [3:0] offset, [11:4] data, [19:12] button_number, [20] button_pressed,
  // [28:21] click_count, [31:29] zero
  input  wire logic [31:0] s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] read_data, [8] cursor_dirty, [15:9] zero
  output logic [15:0]      m_axis_tdata_o
);

  localparam int unsigned CELLS     = CURSOR_SIDE * CURSOR_SIDE;
  localparam int unsigned AW        = $clog2(CELLS);
  localparam int unsigned MOD_STEPS = 255 / CELLS;

  function automatic logic [AW-1:0] cell_of(input logic [7:0] idx);
    logic [8:0] v;
    v = {1'b0, idx};
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (v >= 9'(CELLS)) begin
        v = v - 9'(CELLS);
      end
    end
    return v[AW-1:0];
  endfunction

  function automatic logic [2:0] mod7(input logic [7:0] n);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(n[7:6]) + 5'(n[5:3]) + 5'(n[2:0]);
    t = 4'(s[4:3]) + 4'(s[2:0]);
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

  logic        accept;
  logic        advance;

  logic        s1_vld_q;
  kind_e       s1_kind_q;
  req_t        s1_req_q;

  logic        out_vld_q;
  logic [8:0]  out_data_q, out_data_d;

  logic [15:0] pos_x_q, pos_x_d;
  logic [15:0] pos_y_q, pos_y_d;
  logic [7:0]  ofs_x_q, ofs_x_d;
  logic [7:0]  ofs_y_q, ofs_y_d;
  logic [7:0]  wheel_q, wheel_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  index_q, index_d;
  logic [AW-1:0] cell_q, cell_d;
  logic        dirty_q, dirty_d;
  logic [CELLS-1:0] vld_q, vld_d;

  logic        fwd_q, fwd_d;
  logic [7:0]  fwd_data_q;

  logic        ram_we;
  logic [7:0]  ram_rdata;
  logic [7:0]  bm_rd;
  logic [7:0]  rd;
  logic [2:0]  sel;
  logic        rd_wheel;
  logic        rd_unmapped;

  assign advance         = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, out_data_q};

  assign sel   = mod7(s1_req_q.button_number);
  assign bm_rd = vld_q[cell_q] ? (fwd_q ? fwd_data_q : ram_rdata) : 8'd0;

  assign rd_wheel    = advance && (s1_kind_q == KIND_READ) && (s1_req_q.offset == OFS_WHEEL);
  assign rd_unmapped = advance && (s1_kind_q == KIND_READ) && (s1_req_q.offset > OFS_DATA);

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    ofs_x_d = ofs_x_q;
    ofs_y_d = ofs_y_q;
    wheel_d = wheel_q;
    flags_d = flags_q;
    index_d = index_q;
    cell_d  = cell_q;
    dirty_d = dirty_q;
    vld_d   = vld_q;
    ram_we  = 1'b0;
    rd      = 8'd0;
    if (advance) begin
      unique case (s1_kind_q)
        KIND_READ: begin
          unique case (s1_req_q.offset)
            OFS_X_HI:  rd = pos_x_q[15:8];
            OFS_X_LO:  rd = pos_x_q[7:0];
            OFS_Y_HI:  rd = pos_y_q[15:8];
            OFS_Y_LO:  rd = pos_y_q[7:0];
            OFS_XOFS:  rd = ofs_x_q;
            OFS_YOFS:  rd = ofs_y_q;
            OFS_WHEEL: begin
              rd      = wheel_q;
              wheel_d = 8'd0;
            end
            OFS_FLAGS: rd = flags_q;
            OFS_INDEX: rd = index_q;
            OFS_DATA:  rd = bm_rd;
            default:   rd = UNMAPPED_VALUE;
          endcase
        end
        KIND_WRITE: begin
          unique case (s1_req_q.offset)
            OFS_X_HI: begin
              pos_x_d[15:8] = s1_req_q.data;
              dirty_d       = 1'b1;
            end
            OFS_X_LO: begin
              pos_x_d[7:0] = s1_req_q.data;
              dirty_d      = 1'b1;
            end
            OFS_Y_HI: begin
              pos_y_d[15:8] = s1_req_q.data;
              dirty_d       = 1'b1;
            end
            OFS_Y_LO: begin
              pos_y_d[7:0] = s1_req_q.data;
              dirty_d      = 1'b1;
            end
            OFS_XOFS: begin
              ofs_x_d = s1_req_q.data;
              dirty_d = 1'b1;
            end
            OFS_YOFS: begin
              ofs_y_d = s1_req_q.data;
              dirty_d = 1'b1;
            end
            OFS_WHEEL: wheel_d = s1_req_q.data;
            OFS_INDEX: begin
              index_d = s1_req_q.data;
              cell_d  = cell_of(s1_req_q.data);
            end
            OFS_DATA: begin
              ram_we        = 1'b1;
              vld_d[cell_q] = 1'b1;
              dirty_d       = 1'b1;
            end
            default: ;
          endcase
        end
        KIND_BUTTON: begin
          flags_d = 8'd0;
          if (s1_req_q.button_pressed) begin
            if (sel != 3'd0) begin
              flags_d = 8'd1 << (sel - 3'd1);
            end
            flags_d[7:6] = s1_req_q.click_count[1:0];
          end
        end
        KIND_REFRESH: dirty_d = 1'b0;
        default: ;
      endcase
    end
  end

  assign out_data_d = {dirty_d, rd};
  assign fwd_d      = ram_we;

  mcrf_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cell_q),
    .wdata_i(s1_req_q.data),
    .re_i   (accept),
    .raddr_i(cell_d),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      ofs_x_q   <= '0;
      ofs_y_q   <= '0;
      wheel_q   <= '0;
      flags_q   <= '0;
      index_q   <= '0;
      cell_q    <= '0;
      dirty_q   <= 1'b0;
      vld_q     <= '0;
      fwd_q     <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
        fwd_q    <= fwd_d;
      end else if (advance) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      ofs_x_q <= ofs_x_d;
      ofs_y_q <= ofs_y_d;
      wheel_q <= wheel_d;
      flags_q <= flags_d;
      index_q <= index_d;
      cell_q  <= cell_d;
      dirty_q <= dirty_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= kind_e'(s_axis_tuser_i);
      s1_req_q   <= '{
        offset:         s_axis_tdata_i[3:0],
        data:           s_axis_tdata_i[11:4],
        button_number:  s_axis_tdata_i[19:12],
        button_pressed: s_axis_tdata_i[20],
        click_count:    s_axis_tdata_i[28:21]
      };
      fwd_data_q <= s1_req_q.data;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  `MCRF_ASSERT_SAME(a_no_overrun, out_vld_q && !m_axis_tready_i, !advance, "result overrun")
  `MCRF_ASSERT_NEXT(a_refresh_clears, advance && (s1_kind_q == KIND_REFRESH), !dirty_q && !out_data_q[8], "refresh left dirty set")
  `MCRF_ASSERT_NEXT(a_wheel_clears, rd_wheel, wheel_q == 8'd0, "wheel not cleared on read")
  `MCRF_ASSERT_NEXT(a_unmapped_read, rd_unmapped, out_data_q[7:0] == UNMAPPED_VALUE, "unmapped read value wrong")

endmodule

`default_nettype wire

### src/mcrf_ram.sv
`default_nettype none

module mcrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
